>>> rtl/tpce_pkg.sv
package tpce_pkg;

    // Pool and alphabet sizing
    localparam int NODES     = 65536;
    localparam int ALPHABET  = 26;
    localparam int TAG_WIDTH = 16;

    localparam int NODE_W  = $clog2(NODES);
    localparam int FREE_W  = NODE_W + 1;
    localparam int SYM_W   = 5;
    localparam int COUNT_W = 16;
    localparam int SLOT_W  = $clog2(NODES * ALPHABET);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [ALPHABET-1:0] mask_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // One node record: distinct-word count, last tag, child presence bits
    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [TAG_WIDTH-1:0] tag;
        mask_t                mask;
    } node_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHILD,
        ST_NODE,
        ST_ALLOC,
        ST_EMIT
    } state_t;

    // Child table address: node * ALPHABET + symbol
    function automatic slot_t slot_addr(input node_t node, input logic [SYM_W-1:0] sym);
        return SLOT_W'(SLOT_W'(node) * SLOT_W'(ALPHABET) + SLOT_W'(sym));
    endfunction

endpackage

>>> rtl/trie_prefix_count_engine.sv
// Prefix trie with distinct-word counts. Each input transaction carries one
// symbol tagged insert or query; restart sends the walk back to the root.
// An insert follows or allocates one edge and counts its word tag once per
// node; a query follows one edge and, on its last symbol, returns one result
// transaction with the reached node's count (0 on a miss) and the sticky pool
// overflow flag. All trie state sits in two synchronous RAMs: the child table
// (NODES*ALPHABET entries of node numbers) and the node record RAM (count, last
// tag and a child-presence mask per node). Each transaction's work follows
// the dependent RAM accesses: at most one child-table read when the symbol
// is skipped or the query misses; a child-table read, then a node-record
// read (rewritten by an insert) when the walk moves to a child; a child-table
// write plus up to two node-record writes when it allocates a node. A query result
// waits in an output register; a new result can stall the engine only while
// the previous one is still held there. The presence mask is written when a
// node is allocated and the root mask lives in flops, so no RAM clearing pass
// is needed after reset: the engine accepts transactions as soon as reset
// is released.
module trie_prefix_count_engine
    import tpce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input transaction channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 action,
    input  logic                 restart,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [15:0]          word_tag,
    input  logic                 last,
    // result transaction channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [COUNT_W-1:0]   match_count,
    output logic                 overflowed
);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    node_t     child_mem [NODES*ALPHABET];
    node_rec_t node_mem  [NODES];

    // control registers
    state_t             state_reg, state_next;
    node_t              cur_reg, cur_next;
    mask_t              root_mask_reg, root_mask_next;
    logic [FREE_W-1:0]  next_free_reg, next_free_next;
    logic               missed_reg, missed_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic                 action_reg;
    logic                 last_reg;
    logic [SYM_W-1:0]     sym_reg;
    logic                 sym_ok_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    slot_t                slot_reg;
    node_rec_t            cur_rec_reg, cur_rec_next;
    logic [COUNT_W-1:0]   res_pend_reg, res_pend_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_ovf_reg, out_ovf_next;
    node_t                child_rd_reg;
    node_rec_t            node_rd_reg;

    // RAM ports
    logic      ch_re, ch_we;
    slot_t     ch_raddr, ch_waddr;
    node_t     ch_wdata;
    logic      nd_re, nd_we;
    node_t     nd_raddr, nd_waddr;
    node_rec_t nd_wdata;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic      accept;
    logic      sym_ok_in;
    node_t     cur_eff;
    logic      missed_eff;
    logic      is_root;
    mask_t     mask_sel;
    mask_t     sym_bit;
    logic      present;
    logic      pool_full;
    logic      out_free;
    logic      res_have;
    logic [COUNT_W-1:0] res_value;
    logic      res_load;
    node_rec_t upd_rec;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign sym_ok_in  = (32'(symbol) < ALPHABET);
    assign cur_eff    = restart ? '0 : cur_reg;
    assign missed_eff = (action == ACT_QUERY && restart) ? 1'b0 : missed_reg;

    assign is_root   = (cur_reg == '0);
    assign mask_sel  = is_root ? root_mask_reg : cur_rec_reg.mask;
    assign sym_bit   = mask_t'(1) << sym_reg;
    assign present   = sym_ok_reg && ((mask_sel & sym_bit) != '0);
    assign pool_full = next_free_reg[NODE_W];
    assign out_free  = !out_valid_reg || !result_stall;

    // existing child reached by an insert: count the tag once
    always_comb
    begin
        upd_rec     = node_rd_reg;
        upd_rec.tag = tag_reg;
        if (node_rd_reg.tag != tag_reg && node_rd_reg.count != COUNT_MAX)
        begin
            upd_rec.count = node_rd_reg.count + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHILD;
                end
            end
            ST_CHILD:
            begin
                if (action_reg == ACT_INSERT)
                begin
                    if (ovf_reg || !sym_ok_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (present)
                    begin
                        state_next = ST_NODE;
                    end
                    else if (pool_full)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ALLOC;
                    end
                end
                else if (!missed_reg && present)
                begin
                    state_next = ST_NODE;
                end
                else if (res_have && !out_free)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NODE:
            begin
                if (res_have && !out_free)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_next       = cur_reg;
        cur_rec_next   = cur_rec_reg;
        root_mask_next = root_mask_reg;
        next_free_next = next_free_reg;
        missed_next    = missed_reg;
        ovf_next       = ovf_reg;
        res_pend_next  = res_pend_reg;
        res_have       = 1'b0;
        res_value      = '0;

        ch_re    = 1'b0;
        ch_raddr = slot_addr(cur_eff, symbol);
        ch_we    = 1'b0;
        ch_waddr = slot_reg;
        ch_wdata = next_free_reg[NODE_W-1:0];
        nd_re    = 1'b0;
        nd_raddr = child_rd_reg;
        nd_we    = 1'b0;
        nd_waddr = cur_reg;
        nd_wdata = cur_rec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next    = cur_eff;
                    missed_next = missed_eff;
                    ch_re       = sym_ok_in &&
                                  ((action == ACT_INSERT) ? !ovf_reg : !missed_eff);
                end
            end
            ST_CHILD:
            begin
                if (action_reg == ACT_INSERT)
                begin
                    if (!ovf_reg && sym_ok_reg)
                    begin
                        if (present)
                        begin
                            nd_re = 1'b1;
                        end
                        else if (pool_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            // link the new node under its parent
                            ch_we = 1'b1;
                            if (is_root)
                            begin
                                root_mask_next = root_mask_reg | sym_bit;
                            end
                            else
                            begin
                                nd_we         = 1'b1;
                                nd_wdata.mask = cur_rec_reg.mask | sym_bit;
                            end
                        end
                    end
                end
                else if (!missed_reg && present)
                begin
                    nd_re = 1'b1;
                end
                else
                begin
                    missed_next = 1'b1;
                    res_have    = last_reg;
                end
            end
            ST_NODE:
            begin
                cur_next = child_rd_reg;
                if (action_reg == ACT_INSERT)
                begin
                    nd_we        = 1'b1;
                    nd_waddr     = child_rd_reg;
                    nd_wdata     = upd_rec;
                    cur_rec_next = upd_rec;
                end
                else
                begin
                    cur_rec_next = node_rd_reg;
                    res_have     = last_reg;
                    res_value    = node_rd_reg.count;
                end
            end
            ST_ALLOC:
            begin
                // fresh node: count one, this tag, no children
                nd_we          = 1'b1;
                nd_waddr       = next_free_reg[NODE_W-1:0];
                nd_wdata       = '{count: COUNT_W'(1), tag: tag_reg, mask: '0};
                cur_next       = next_free_reg[NODE_W-1:0];
                cur_rec_next   = nd_wdata;
                next_free_next = next_free_reg + 1'b1;
            end
            ST_EMIT:
            begin
                res_have  = 1'b1;
                res_value = res_pend_reg;
            end
            default:
            begin
            end
        endcase

        if (res_have && !out_free)
        begin
            res_pend_next = res_value;
        end
    end

    assign res_load = res_have && out_free;

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_count_next = res_value;
            out_ovf_next   = ovf_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign match_count  = out_count_reg;
    assign overflowed   = out_ovf_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            root_mask_reg <= '0;
            next_free_reg <= FREE_W'(1);
            missed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            root_mask_reg <= root_mask_next;
            next_free_reg <= next_free_next;
            missed_reg    <= missed_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            last_reg   <= last;
            sym_reg    <= symbol;
            sym_ok_reg <= sym_ok_in;
            tag_reg    <= word_tag[TAG_WIDTH-1:0];
            slot_reg   <= slot_addr(cur_eff, symbol);
        end
        cur_rec_reg   <= cur_rec_next;
        res_pend_reg  <= res_pend_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // child table RAM
    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            child_mem[ch_waddr] <= ch_wdata;
        end
        if (ch_re)
        begin
            child_rd_reg <= child_mem[ch_raddr];
        end
    end

    // node record RAM
    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            node_mem[nd_waddr] <= nd_wdata;
        end
        if (nd_re)
        begin
            node_rd_reg <= node_mem[nd_raddr];
        end
    end

endmodule

>>> rtl/tpce_checker.sv
module tpce_checker
    import tpce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [COUNT_W-1:0] match_count,
    input  logic               overflowed
);

    logic seen_ovf_reg, seen_ovf_next;

    assign seen_ovf_next = seen_ovf_reg || (result_valid && overflowed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_ovf_reg <= 1'b0;
        end
        else
        begin
            seen_ovf_reg <= seen_ovf_next;
        end
    end

    // overflow is sticky across results
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_ovf_reg |-> overflowed)
        else $error("overflow flag dropped after being reported");

    // every accepted symbol moves the engine out of idle, so it stalls before taking another
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("transaction accepted on back-to-back cycles");

    // a new result only comes out of work on an accepted transaction
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared while engine was idle");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(match_count) && $stable(overflowed))
        else $error("stalled result changed");

endmodule

bind trie_prefix_count_engine tpce_checker u_tpce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .match_count  (match_count),
    .overflowed   (overflowed)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tpce_pkg::*;

    // ------------------------------------------------------------------
    // Transaction types
    // ------------------------------------------------------------------
    // One input transaction: a single symbol of an insert or query walk.
    typedef struct packed {
        logic             action;
        logic             restart;
        logic [SYM_W-1:0] symbol;
        logic [15:0]      word_tag;
        logic             last;
    } sym_item_t;

    // One result transaction as the trie should report it.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } count_rec_t;

    localparam int HOLD_CYCLES = 400;  // long receiver hold-off
    localparam int WORD_SLOTS  = 64;   // recently inserted words kept for queries
    localparam int WORD_MAX    = 6;

    // ------------------------------------------------------------------
    // Clock, reset, DUT signals
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic               action       = ACT_INSERT;
    logic               restart      = 1'b0;
    logic [SYM_W-1:0]   symbol       = '0;
    logic [15:0]        word_tag     = '0;
    logic               last         = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [COUNT_W-1:0] match_count;
    logic               overflowed;

    trie_prefix_count_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .restart      (restart),
        .symbol       (symbol),
        .word_tag     (word_tag),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_count  (match_count),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus / scoreboard storage and knobs
    // ------------------------------------------------------------------
    sym_item_t  symbol_queue[$];     // transactions waiting for the driver
    count_rec_t pending_counts[$];   // counts the trie owes, oldest first
    count_rec_t head_rec;
    int         mismatch_count = 0;

    // Idle knobs, in percent of cycles; changed only at negedge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long hold-off handshake: main thread bumps hold_reqs, the result side
    // notices the change and counts the stall down on its own.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // ------------------------------------------------------------------
    // Trie shadow: same walk rules as the engine, sparse child map.
    // A child entry that was never written reads as "no child".
    // ------------------------------------------------------------------
    int unsigned        child_of [int unsigned];
    logic [COUNT_W-1:0] hits_mem [NODES];
    logic [TAG_WIDTH-1:0] tag_mem [NODES];
    int unsigned        free_ptr   = 1;   // node 0 is the root
    int unsigned        at_node    = 0;
    bit                 q_miss     = 1'b0;
    bit                 pool_full  = 1'b0;

    // Advance the shadow trie by one accepted transaction; a query symbol
    // marked last queues the count the engine must return.
    function automatic void walk_trie(input sym_item_t it);
        int unsigned key;
        int unsigned nxt;
        count_rec_t  owed;
        if (it.restart)
            at_node = 0;
        if (it.action == ACT_INSERT)
        begin
            // Overflow freezes the trie; bad symbols only get the root move.
            if (pool_full || it.symbol >= ALPHABET)
                return;
            key = at_node * ALPHABET + it.symbol;
            nxt = child_of.exists(key) ? child_of[key] : 0;
            if (nxt == 0)
            begin
                if (free_ptr >= NODES)
                begin
                    pool_full = 1'b1;
                    return;
                end
                nxt = free_ptr;
                free_ptr++;
                hits_mem[nxt] = COUNT_W'(1);
                tag_mem[nxt]  = it.word_tag[TAG_WIDTH-1:0];
                child_of[key] = nxt;
            end
            else
            begin
                // Count each source word once per node, saturating.
                if (tag_mem[nxt] != it.word_tag[TAG_WIDTH-1:0] && hits_mem[nxt] != COUNT_MAX)
                    hits_mem[nxt] = hits_mem[nxt] + 1'b1;
                tag_mem[nxt] = it.word_tag[TAG_WIDTH-1:0];
            end
            at_node = nxt;
            return;
        end
        // Query: a miss sticks until the next query restart.
        if (it.restart)
            q_miss = 1'b0;
        if (!q_miss)
        begin
            key = at_node * ALPHABET + it.symbol;
            if (it.symbol >= ALPHABET || !child_of.exists(key))
                q_miss = 1'b1;
            else
                at_node = child_of[key];
        end
        if (it.last)
        begin
            owed.count     = q_miss ? '0 : hits_mem[at_node];
            owed.ovf       = pool_full;
            pending_counts = {pending_counts, owed};
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued transactions, shadows each accepted one.
    // A held transaction keeps its payload until accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            action     <= ACT_INSERT;
            restart    <= 1'b0;
            symbol     <= '0;
            word_tag   <= '0;
            last       <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                walk_trie('{action, restart, symbol, word_tag, last});
            if (!item_valid || !item_stall)
            begin
                if (symbol_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    action     <= symbol_queue[0].action;
                    restart    <= symbol_queue[0].restart;
                    symbol     <= symbol_queue[0].symbol;
                    word_tag   <= symbol_queue[0].word_tag;
                    last       <= symbol_queue[0].last;
                    void'(symbol_queue.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest owed count,
    // and drives the receiver stall (random, or a long hold-off).
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch("result transaction with nothing owed");
                else
                begin
                    head_rec = pending_counts.pop_front();
                    if (match_count !== head_rec.count)
                        report_mismatch($sformatf("match_count %0d, want %0d",
                                                  match_count, head_rec.count));
                    if (overflowed !== head_rec.ovf)
                        report_mismatch($sformatf("overflowed %0b, want %0b",
                                                  overflowed, head_rec.ovf));
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen    <= hold_reqs;
                hold_left    <= HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] word_syms [WORD_SLOTS][WORD_MAX];
    int               word_len  [WORD_SLOTS];
    int               words_kept = 0;
    int               gen_made   = 0;

    task automatic put_sym(input logic act, input logic rs, input int sym,
                           input int tag, input logic lst);
        sym_item_t it;
        it.action   = act;
        it.restart  = rs;
        it.symbol   = sym[SYM_W-1:0];
        it.word_tag = tag[15:0];
        it.last     = lst;
        symbol_queue = {symbol_queue, it};
    endtask

    // Insert every suffix of a fresh word under one tag, as a host would
    // when indexing substrings. Narrow alphabet most of the time so paths
    // share prefixes; a quarter of the words take a small tag set, making repeats common.
    task automatic add_word_suffixes();
        int len;
        int tag;
        int ws;
        int s;
        int k;
        bit wide;
        len  = $urandom_range(WORD_MAX, 1);
        wide = ($urandom_range(3) == 0);
        tag  = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(65535);
        ws   = words_kept % WORD_SLOTS;
        for (k = 0; k < len; k++)
            word_syms[ws][k] = SYM_W'(wide ? $urandom_range(25) : $urandom_range(3));
        word_len[ws] = len;
        words_kept++;
        for (s = 0; s < len; s++)
            for (k = s; k < len; k++)
            begin
                put_sym(ACT_INSERT, k == s, word_syms[ws][k], tag, 1'($urandom_range(1)));
                gen_made++;
            end
    endtask

    // Random short query; sometimes wide symbols, no restart, or no last.
    task automatic query_free();
        int len;
        int k;
        bit wide;
        bit cont;
        bit drop_last;
        len       = $urandom_range(4, 1);
        wide      = ($urandom_range(4) == 0);
        cont      = ($urandom_range(5) == 0);
        drop_last = ($urandom_range(7) == 0);
        for (k = 0; k < len; k++)
        begin
            put_sym(ACT_QUERY, (k == 0) && !cont,
                    wide ? $urandom_range(31) : $urandom_range(3),
                    $urandom, (k == len - 1) && !drop_last);
            gen_made++;
        end
    endtask

    // Query a substring of a word inserted earlier: mostly a hit.
    task automatic query_known();
        int ws;
        int a;
        int b;
        int k;
        if (words_kept == 0)
        begin
            query_free();
            return;
        end
        ws = $urandom_range(((words_kept < WORD_SLOTS) ? words_kept : WORD_SLOTS) - 1);
        a  = $urandom_range(word_len[ws] - 1);
        b  = $urandom_range(word_len[ws] - 1, a);
        for (k = a; k <= b; k++)
        begin
            put_sym(ACT_QUERY, k == a, word_syms[ws][k], $urandom, k == b);
            gen_made++;
        end
    endtask

    task automatic gen_random(input int n);
        int pick;
        gen_made = 0;
        while (gen_made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                add_word_suffixes();
            else if (pick < 75)
                query_known();
            else if (pick < 88)
                query_free();
            else
            begin
                // raw noise: every field fully random
                put_sym(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(31),
                        $urandom_range(65535), 1'($urandom_range(1)));
                gen_made++;
            end
        end
    endtask

    task automatic set_idling(input int s_pct, input int r_pct);
        @(negedge clk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
    endtask

    // Sender pause: everything offered, accepted and answered.
    task automatic drain();
        while (symbol_queue.size() != 0 || item_valid || pending_counts.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: symbols a=0, q=16, y=24, z=25; 26 and 31 are out of range.
        put_sym(ACT_QUERY,  1, 0,  16'h0000, 1);  // empty trie: miss
        put_sym(ACT_INSERT, 1, 0,  16'h0000, 0);  // word 0: "az"
        put_sym(ACT_INSERT, 0, 25, 16'h0000, 1);  // last is don't-care on inserts
        put_sym(ACT_INSERT, 1, 0,  16'hFFFF, 0);  // second word hits "a"
        put_sym(ACT_INSERT, 1, 0,  16'hFFFF, 0);  // same word again: no recount
        put_sym(ACT_QUERY,  1, 0,  16'hFFFF, 1);  // "a" -> 2
        put_sym(ACT_QUERY,  1, 0,  16'h0000, 0);
        put_sym(ACT_QUERY,  0, 25, 16'h1234, 1);  // "az" -> 1
        put_sym(ACT_QUERY,  1, 1,  16'h0000, 0);  // "b" absent
        put_sym(ACT_QUERY,  0, 0,  16'h0000, 1);  // stays a miss after "b"
        put_sym(ACT_INSERT, 1, 26, 16'h0005, 0);  // bad symbol: root move only
        put_sym(ACT_INSERT, 0, 0,  16'h0005, 0);  // walks from root: "a" -> 3
        put_sym(ACT_INSERT, 1, 31, 16'h0005, 1);
        put_sym(ACT_QUERY,  1, 31, 16'h0000, 1);  // bad query symbol: miss
        put_sym(ACT_QUERY,  1, 26, 16'h0000, 1);
        put_sym(ACT_INSERT, 1, 16, 16'hA5A5, 0);  // "q"
        put_sym(ACT_QUERY,  1, 16, 16'h5A5A, 1);
        // Mixed walk: query lands on "a", insert continues from there.
        put_sym(ACT_QUERY,  1, 0,  16'h0000, 0);
        put_sym(ACT_INSERT, 0, 25, 16'h0007, 0);  // "az" -> 2
        put_sym(ACT_QUERY,  0, 25, 16'h0000, 1);  // from "az": no child z
        put_sym(ACT_QUERY,  1, 0,  16'h0000, 0);
        put_sym(ACT_QUERY,  0, 25, 16'h0000, 1);  // "az" -> 2
        drain();

        // Random traffic under each idling mix.
        set_idling(0, 0);
        gen_random(340);
        drain();
        set_idling(87, 0);
        gen_random(340);
        drain();
        set_idling(0, 87);
        gen_random(340);
        drain();
        set_idling(26, 26);
        gen_random(340);
        drain();

        // Back-pressure: receiver holds off while the sender keeps going,
        // so the held result backs up into the input channel.
        set_idling(0, 0);
        hold_reqs = hold_reqs + 1;
        gen_random(200);
        drain();

        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
